@@ rtl/core/rnpm_pkg.sv @@
// Shared types, codes and widths for the radius nearest point match block.
// No dependencies; every other file in rtl/core uses it by scoped names.
package rnpm_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int COORD_W  = 30;
	localparam int ELEV_W   = 32;
	localparam int RADIUS_W = 24;
	localparam int R2_W     = 2 * RADIUS_W;
	localparam int MAG_W    = COORD_W + 1;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int D2_W     = SQ_W + 1;
	localparam int DIST_LAT = 3;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3000);

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_SPARE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ELEV_W-1:0]  elev;
		logic               ok;
	} label_t;

	typedef struct packed {
		logic   live;
		label_t lab;
	} head_t;

	typedef struct packed {
		logic              found;
		logic              ok;
		logic [ELEV_W-1:0] elev;
	} best_t;

endpackage

@@ rtl/core/rnpm_if.sv @@
// Valid/ready channel interfaces for input words and result words.
// Depends on rnpm_pkg for field widths.
interface rnpm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           kind;
	logic signed [rnpm_pkg::COORD_W-1:0]  pos_x;
	logic signed [rnpm_pkg::COORD_W-1:0]  pos_y;
	logic signed [rnpm_pkg::ELEV_W-1:0]   elevation_mm;
	logic                                 elevation_ok;

	modport source (output valid, kind, pos_x, pos_y, elevation_mm, elevation_ok,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, elevation_mm, elevation_ok,
		output ready);
endinterface

interface rnpm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 matched;
	logic signed [rnpm_pkg::COORD_W-1:0]  match_x;
	logic signed [rnpm_pkg::COORD_W-1:0]  match_y;
	logic signed [rnpm_pkg::ELEV_W-1:0]   match_elevation_mm;
	logic                                 load_dropped;

	modport source (output valid, matched, match_x, match_y, match_elevation_mm,
		load_dropped, input ready);
	modport sink (input valid, matched, match_x, match_y, match_elevation_mm,
		load_dropped, output ready);
endinterface

@@ rtl/core/rnpm_cell.sv @@
// One cell of the label ring: holds one stored label, loads it on a write
// or takes its neighbor's label on a shift. Depends on rnpm_pkg.
module rnpm_cell (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              shift_en,
	input  rnpm_pkg::label_t  wr_lab,
	input  rnpm_pkg::label_t  nxt_lab,
	output rnpm_pkg::label_t  cur_lab
);

	rnpm_pkg::label_t lab_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lab_q <= wr_lab;
		end else if (shift_en) begin
			lab_q <= nxt_lab;
		end
	end

	assign cur_lab = lab_q;

endmodule

@@ rtl/core/rnpm_dist.sv @@
// Pipelined distance unit at the head of the ring: squared distance of the
// head label to the query, radius test and running nearest. Depends on rnpm_pkg.
module rnpm_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clr,
	input  rnpm_pkg::head_t                     head,
	input  logic [rnpm_pkg::COORD_W-1:0]        qx,
	input  logic [rnpm_pkg::COORD_W-1:0]        qy,
	input  logic [rnpm_pkg::R2_W-1:0]           r2,
	output rnpm_pkg::best_t                     best
);

	localparam int MAG_W = rnpm_pkg::MAG_W;
	localparam int SQ_W  = rnpm_pkg::SQ_W;
	localparam int D2_W  = rnpm_pkg::D2_W;
	localparam int EW    = rnpm_pkg::ELEV_W;

	logic [MAG_W-1:0] diff_x, diff_y, mag_x, mag_y;

	logic              v_s1, v_s2, v_s3;
	logic [MAG_W-1:0]  dx_s1, dy_s1;
	logic [SQ_W-1:0]   dx2_s2, dy2_s2;
	logic [D2_W-1:0]   d2_s3;
	logic [EW-1:0]     elev_s1, elev_s2, elev_s3;
	logic              ok_s1, ok_s2, ok_s3;

	logic              found_q, best_ok_q;
	logic [D2_W-1:0]   best_d2_q;
	logic [EW-1:0]     best_elev_q;
	logic              take;

	always_comb begin
		diff_x = {qx[rnpm_pkg::COORD_W-1], qx} -
			{head.lab.x[rnpm_pkg::COORD_W-1], head.lab.x};
		diff_y = {qy[rnpm_pkg::COORD_W-1], qy} -
			{head.lab.y[rnpm_pkg::COORD_W-1], head.lab.y};
		mag_x  = diff_x[MAG_W-1] ? (~diff_x + MAG_W'(1)) : diff_x;
		mag_y  = diff_y[MAG_W-1] ? (~diff_y + MAG_W'(1)) : diff_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= head.live;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= mag_x;
		dy_s1   <= mag_y;
		elev_s1 <= head.lab.elev;
		ok_s1   <= head.lab.ok;

		dx2_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		dy2_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		elev_s2 <= elev_s1;
		ok_s2   <= ok_s1;

		d2_s3   <= D2_W'(dx2_s2) + D2_W'(dy2_s2);
		elev_s3 <= elev_s2;
		ok_s3   <= ok_s2;
	end

	// strict less-than keeps the earliest label on a tie
	assign take = v_s3 && (d2_s3 <= D2_W'(r2)) && (!found_q || (d2_s3 < best_d2_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_d2_q   <= d2_s3;
			best_elev_q <= elev_s3;
			best_ok_q   <= ok_s3;
		end
	end

	assign best.found = found_q;
	assign best.ok    = best_ok_q;
	assign best.elev  = best_elev_q;

endmodule

@@ rtl/core/radius_nearest_point_match_core.sv @@
// Radius nearest point match: labels sit in a ring of TABLE_DEPTH cells that
// rotates one entry per cycle while scanning, past a three-stage distance unit.
// An accepted query makes one full rotation of the ring, drains the distance
// pipeline and posts its result once the output register is free. Load, clear
// and unused words go straight to posting a result. The next word is taken
// once the block is back in idle, even while the previous result still waits in
// the output register. Reset empties the table only by setting the count to
// zero; there is no clearing pass. The radius register sits at byte address 0.
// Depends on rnpm_pkg, rnpm_if, rnpm_cell and rnpm_dist.
module radius_nearest_point_match_core #(
	parameter int TABLE_DEPTH = rnpm_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	rnpm_in_if.sink          in_ch,
	rnpm_out_if.source       out_ch
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CW    = rnpm_pkg::COORD_W;
	localparam int EW    = rnpm_pkg::ELEV_W;
	localparam int RW    = rnpm_pkg::RADIUS_W;
	localparam int LAT_W = $clog2(rnpm_pkg::DIST_LAT);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          scan_q;
	logic [LAT_W-1:0]          drain_q;
	logic [RW-1:0]             radius_q;
	logic [rnpm_pkg::R2_W-1:0] r2_q;
	logic [1:0]                kind_q;
	logic [CW-1:0]             qx_q, qy_q;
	logic                      drop_q;
	logic                      out_valid_q;
	logic                      out_matched_q, out_drop_q;
	logic [CW-1:0]             out_x_q, out_y_q;
	logic [EW-1:0]             out_elev_q;

	logic                      accept, is_load, is_query, is_clear, full;
	logic                      load_we, shifting, post;
	logic                      cfg_we;
	logic                      res_match;
	rnpm_pkg::label_t          wr_lab;
	rnpm_pkg::label_t          ring [TABLE_DEPTH];
	rnpm_pkg::head_t           head;
	rnpm_pkg::best_t           best;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(radius_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= rnpm_pkg::RADIUS_RESET;
			r2_q     <= rnpm_pkg::R2_W'(rnpm_pkg::RADIUS_RESET) *
				rnpm_pkg::R2_W'(rnpm_pkg::RADIUS_RESET);
		end else if (cfg_we) begin
			radius_q <= pwdata[RW-1:0];
			r2_q     <= rnpm_pkg::R2_W'(pwdata[RW-1:0]) * rnpm_pkg::R2_W'(pwdata[RW-1:0]);
		end
	end

	// input decode
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_load     = (in_ch.kind == rnpm_pkg::KIND_LOAD);
	assign is_query    = (in_ch.kind == rnpm_pkg::KIND_QUERY);
	assign is_clear    = (in_ch.kind == rnpm_pkg::KIND_CLEAR);
	assign full        = (count_q == CNT_W'(TABLE_DEPTH));
	assign load_we     = accept && is_load && !full;
	assign shifting    = (state_q == ST_SCAN);

	assign wr_lab.x    = in_ch.pos_x;
	assign wr_lab.y    = in_ch.pos_y;
	assign wr_lab.elev = in_ch.elevation_mm;
	assign wr_lab.ok   = in_ch.elevation_ok;

	// label ring: cell 0 feeds the distance unit, each cell takes its right neighbor
	for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
		rnpm_cell u_cell (
			.clk      (clk),
			.wr_en    (load_we && (count_q == CNT_W'(j))),
			.shift_en (shifting),
			.wr_lab   (wr_lab),
			.nxt_lab  (ring[(j + 1) % TABLE_DEPTH]),
			.cur_lab  (ring[j])
		);
	end

	assign head.live = shifting && (scan_q < count_q);
	assign head.lab  = ring[0];

	rnpm_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept && is_query),
		.head   (head),
		.qx     (qx_q),
		.qy     (qy_q),
		.r2     (r2_q),
		.best   (best)
	);

	// sequencer
	assign post = (state_q == ST_RESULT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q  <= '0;
						drain_q <= '0;
						if (is_query) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESULT;
						end
						if (load_we) begin
							count_q <= count_q + CNT_W'(1);
						end else if (is_clear) begin
							count_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (scan_q == CNT_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + LAT_W'(1);
					if (drain_q == LAT_W'(rnpm_pkg::DIST_LAT - 1)) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (post) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_ch.kind;
			qx_q   <= in_ch.pos_x;
			qy_q   <= in_ch.pos_y;
			drop_q <= is_load && full;
		end
	end

	// output register: hold the word until the sink takes it
	assign res_match = (kind_q == rnpm_pkg::KIND_QUERY) && best.found && best.ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post) begin
			out_matched_q <= res_match;
			out_x_q       <= res_match ? qx_q : '0;
			out_y_q       <= res_match ? qy_q : '0;
			out_elev_q    <= res_match ? best.elev : '0;
			out_drop_q    <= drop_q;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.matched            = out_matched_q;
	assign out_ch.match_x            = out_x_q;
	assign out_ch.match_y            = out_y_q;
	assign out_ch.match_elevation_mm = out_elev_q;
	assign out_ch.load_dropped       = out_drop_q;

endmodule

@@ rtl/core/rnpm_checker.sv @@
// Port-level checks for the radius nearest point match core, bound to the top.
// Depends on rnpm_pkg and the top level's ports.
module rnpm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         matched,
	input logic [rnpm_pkg::COORD_W-1:0] match_x,
	input logic [rnpm_pkg::COORD_W-1:0] match_y,
	input logic [rnpm_pkg::ELEV_W-1:0]  match_elevation_mm,
	input logic                         load_dropped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(matched) && $stable(match_x) &&
			$stable(match_y) && $stable(match_elevation_mm) && $stable(load_dropped))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in work");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && load_dropped))
		else $error("dropped load reported as a match");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> (match_x == '0) && (match_y == '0) &&
			(match_elevation_mm == '0))
		else $error("unmatched result carries nonzero fields");

endmodule

bind radius_nearest_point_match_core rnpm_checker u_rnpm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_ch.valid),
	.in_ready           (in_ch.ready),
	.out_valid          (out_ch.valid),
	.out_ready          (out_ch.ready),
	.matched            (out_ch.matched),
	.match_x            (out_ch.match_x),
	.match_y            (out_ch.match_y),
	.match_elevation_mm (out_ch.match_elevation_mm),
	.load_dropped       (out_ch.load_dropped)
);
